/* rtl/csvs_pkg.sv */
package csvs_pkg;

    localparam int DATA_W   = 8;
    localparam int COL_OUT_W = 5;
    localparam int POS_OUT_W = 7;
    localparam int CNT_OUT_W = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_CELL = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_CHAR      = 2'd0,
        OP_CELL      = 2'd1,
        OP_LINE      = 2'd2,
        OP_CELL_LINE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_PARSE = 2'd0,
        ST_STOP  = 2'd1,
        ST_FAIL  = 2'd2
    } t_status;

    // One queued command: a single result, or a cell end followed by a line end
    typedef struct packed {
        t_op                  op;
        logic [COL_OUT_W-1:0] column;
        logic [POS_OUT_W-1:0] position;
        logic [DATA_W-1:0]    out_char;
        logic                 line_ok;
        logic [CNT_OUT_W-1:0] cells;
    } t_entry;

    // Output transaction, lowest field last in the packed layout
    typedef struct packed {
        logic [2:0]           pad;
        logic [CNT_OUT_W-1:0] cells;
        logic                 line_ok;
        logic [DATA_W-1:0]    out_char;
        logic [POS_OUT_W-1:0] position;
        logic [COL_OUT_W-1:0] column;
        t_kind                kind;
    } t_result;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

/* rtl/csvs_front.sv */
module csvs_front
    import csvs_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int CELL_BYTES  = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [DATA_W-1:0] i_byte,
    input  logic              i_eol,
    output t_push             o_push
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int CHR_W = $clog2(CELL_BYTES);

    logic             r_in_quotes, n_in_quotes;
    logic             r_qclosed,   n_qclosed;
    logic             r_pending,   n_pending;
    logic [COL_W-1:0] r_col,       n_col;
    logic [CHR_W-1:0] r_char,      n_char;
    t_status          r_status,    n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes <= 1'b0;
            r_qclosed   <= 1'b0;
            r_pending   <= 1'b0;
            r_col       <= '0;
            r_char      <= '0;
            r_status    <= ST_PARSE;
        end else if (i_accept) begin
            r_in_quotes <= n_in_quotes;
            r_qclosed   <= n_qclosed;
            r_pending   <= n_pending;
            r_col       <= n_col;
            r_char      <= n_char;
            r_status    <= n_status;
        end
    end

    always_comb begin
        logic             do_unq;
        logic             do_emit;
        logic             qc_eff;
        logic [7:0]       emit_ch;
        logic [COL_W-1:0] col_inc;
        logic [CHR_W:0]   char_inc;

        n_in_quotes = r_in_quotes;
        n_qclosed   = r_qclosed;
        n_pending   = r_pending;
        n_col       = r_col;
        n_char      = r_char;
        n_status    = r_status;
        o_push      = '0;
        do_unq      = 1'b0;
        do_emit     = 1'b0;
        qc_eff      = r_qclosed;
        emit_ch     = i_byte;
        col_inc     = r_col + COL_W'(1);
        char_inc    = {1'b0, r_char} + (CHR_W+1)'(1);

        if (i_eol) begin
            o_push.push                 = 1'b1;
            o_push.entry.column         = COL_OUT_W'(r_col);
            o_push.entry.position       = POS_OUT_W'(r_char);
            o_push.entry.line_ok        = (r_status != ST_FAIL);
            if (r_status == ST_FAIL) begin
                o_push.entry.op = OP_LINE;
            end else if (r_col < COL_W'(MAX_COLUMNS)) begin
                o_push.entry.op         = OP_CELL_LINE;
                o_push.entry.cells      = CNT_OUT_W'(col_inc);
            end else begin
                o_push.entry.op         = OP_LINE;
                o_push.entry.cells      = CNT_OUT_W'(r_col);
            end
            n_in_quotes = 1'b0;
            n_qclosed   = 1'b0;
            n_pending   = 1'b0;
            n_col       = '0;
            n_char      = '0;
            n_status    = ST_PARSE;
        end else if (r_status == ST_PARSE) begin
            if (r_in_quotes) begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (i_byte == CH_QUOTE) begin
                        do_emit = 1'b1;
                    end else begin
                        n_in_quotes = 1'b0;
                        n_qclosed   = 1'b1;
                        qc_eff      = 1'b1;
                        do_unq      = 1'b1;
                    end
                end else if (i_byte == CH_QUOTE) begin
                    n_pending = 1'b1;
                end else begin
                    do_emit = 1'b1;
                end
            end else begin
                do_unq = 1'b1;
            end

            if (do_unq) begin
                if (i_byte == CH_CR || i_byte == CH_LF) begin
                    n_status = ST_STOP;
                end else if (i_byte == CH_COMMA) begin
                    o_push.push           = 1'b1;
                    o_push.entry.op       = OP_CELL;
                    o_push.entry.column   = COL_OUT_W'(r_col);
                    o_push.entry.position = POS_OUT_W'(r_char);
                    n_col     = col_inc;
                    n_char    = '0;
                    n_qclosed = 1'b0;
                    if (col_inc >= COL_W'(MAX_COLUMNS)) begin
                        n_status = ST_STOP;
                    end
                end else if (i_byte == CH_QUOTE && r_char == '0 && !qc_eff) begin
                    n_in_quotes = 1'b1;
                end else if (qc_eff) begin
                    if (i_byte != CH_SPACE && i_byte != CH_TAB) begin
                        n_status = ST_FAIL;
                    end
                end else begin
                    do_emit = 1'b1;
                end
            end

            // drop characters past the cell limit
            if (do_emit && char_inc < (CHR_W+1)'(CELL_BYTES)) begin
                o_push.push           = 1'b1;
                o_push.entry.op       = OP_CHAR;
                o_push.entry.column   = COL_OUT_W'(r_col);
                o_push.entry.position = POS_OUT_W'(r_char);
                o_push.entry.out_char = emit_ch;
                n_char = CHR_W'(char_inc);
            end
        end
    end

endmodule

/* rtl/csvs_queue.sv */
module csvs_queue
    import csvs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push.push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_full && !i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/csvs_back.sv */
module csvs_back
    import csvs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_entry  i_head,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_last,
    input  logic    i_ready
);

    logic    r_valid, n_valid;
    logic    r_phase, n_phase;
    logic    r_last,  n_last;
    t_result r_data,  n_data;
    logic    load;

    assign load    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_comb begin
        n_valid = r_valid && !i_ready;
        n_phase = r_phase;
        n_last  = r_last;
        n_data  = r_data;
        o_pop   = 1'b0;

        if (load && !i_empty) begin
            n_valid         = 1'b1;
            n_data          = '0;
            n_data.column   = i_head.column;
            n_data.position = i_head.position;
            n_last          = 1'b1;
            unique case (i_head.op)
                OP_CHAR: begin
                    n_data.kind     = KIND_CHAR;
                    n_data.out_char = i_head.out_char;
                    o_pop           = 1'b1;
                end
                OP_CELL: begin
                    n_data.kind = KIND_CELL;
                    o_pop       = 1'b1;
                end
                OP_LINE, OP_CELL_LINE: begin
                    // a combined entry first sends its cell end, then the line end
                    if (i_head.op == OP_CELL_LINE && !r_phase) begin
                        n_data.kind = KIND_CELL;
                        n_last      = 1'b0;
                        n_phase     = 1'b1;
                    end else begin
                        n_data.kind       = KIND_LINE;
                        n_data.column     = '0;
                        n_data.position   = '0;
                        n_data.line_ok    = i_head.line_ok;
                        n_data.cells      = i_head.line_ok ? i_head.cells : '0;
                        n_phase           = 1'b0;
                        o_pop             = 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_empty && i_head.op == OP_CELL_LINE))
        else $error("split entry lost from queue head");
    a_phase_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && r_data.kind == KIND_CELL && !r_last))
        else $error("split entry without pending cell end");
    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.kind == KIND_LINE) |-> r_last)
        else $error("line end not marked last");

endmodule

/* rtl/csv_field_splitter.sv */
// An accepted byte's result is written to the queue, then registered in the output stage.
// Throughput: one byte per cycle while the queue has room; an end-of-line transaction that
// closes an open cell produces two results that hold the output in turn, absorbed by a four-entry queue.
// Input ready drops only while that queue is full.
// Reset (i_rst_n low, synchronous) clears the parser state, the queue and the output valid.
module csv_field_splitter
    import csvs_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int CELL_BYTES  = 72
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // end_of_line
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [1:0] kind, [6:2] column, [13:7] position,
                                     // [21:14] out_char, [22] line_ok, [28:23] cells
    output logic        o_m_tlast    // last
);

    t_push   front_push;
    t_push   q_push;
    t_entry  head;
    t_result result;
    logic    q_full, q_empty, q_pop;

    assign o_s_tready = !q_full;

    // push only on an accepted transaction
    assign q_push.push  = front_push.push && i_s_tvalid && !q_full;
    assign q_push.entry = front_push.entry;

    csvs_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CELL_BYTES  (CELL_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_s_tvalid && !q_full),
        .i_byte   (i_s_tdata),
        .i_eol    (i_s_tlast),
        .o_push   (front_push)
    );

    csvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    csvs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (q_pop),
        .o_valid (o_m_tvalid),
        .o_data  (result),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = result;

endmodule
